### hdl/bebb_pkg.sv
// Shared types, sizes and helper functions for the binary erosion / bounding box core.
// No dependencies; bebb_window, bebb_box and the core import this package.
`default_nettype none

package bebb_pkg;

  // Image size limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Column address and row counter widths follow the limits
  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Fixed field widths of the ports
  localparam int COORD_W = 10;
  localparam int DIM_W   = 11;

  // Reset value of both size registers
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  // Configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // A request from the window can carry up to three decided pixels
  localparam int NUM_SLOTS = 3;
  localparam int SLOT_W    = 2;

  // Slot order within a request
  localparam int SLOT_ABOVE = 0;  // pixel one row above, same column
  localparam int SLOT_LEFT  = 1;  // last row: pixel one column to the left
  localparam int SLOT_HERE  = 2;  // last row, last column: this pixel

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [ADDR_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]   row_t;

  // One decided pixel
  typedef struct packed {
    coord_t row;
    coord_t col;
    logic   land;
    logic   done;
  } dec_t;

  // Decided pixels produced by one input pixel
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    dec_t [NUM_SLOTS-1:0] px;
  } bundle_t;

  // Land stays land when at least two of its four neighbours are land
  function automatic logic erode(input logic mid, input logic up, input logic down,
                                 input logic left, input logic right);
    logic [2:0] n;
    n = 3'(up) + 3'(down) + 3'(left) + 3'(right);
    return mid && (n >= 3'd2);
  endfunction

endpackage

`default_nettype wire

### hdl/binary_erosion_bounding_box_core.sv
// Streaming 4-neighbour binary erosion with bounding box of the remaining land.
// The pixel window and line buffer sit in bebb_window, result sequencing and the
// box in bebb_box, shared definitions in bebb_pkg. Pixels enter in row-major
// order, one per cycle while pix_stall is low, and come out decided one row later
// with their coordinates; the last row is decided one column late, and the
// frame's last pixel comes out with frame_done set and the final box. A pixel is
// taken every cycle on all rows but the last while res_stall is low. There the
// single result port sets the pace: each pixel waits until all results of the
// one before it, up to three for the frame's last pixel, have gone out. The
// line buffer is one 2-bit wide RAM of MAX_WIDTH entries with two read ports;
// it needs no clearing, so the core runs right after reset. Write image_width and
// image_height only while no request is in flight.
`default_nettype none

module binary_erosion_bounding_box_core
  import bebb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire dim_t cfg_data,
  input  wire logic pix_valid,
  output logic      pix_stall,
  input  wire logic land,
  output logic      res_valid,
  input  wire logic res_stall,
  output coord_t    out_row,
  output coord_t    out_col,
  output logic      land_after,
  output coord_t    box_min_row,
  output coord_t    box_max_row,
  output coord_t    box_min_col,
  output coord_t    box_max_col,
  output logic      box_valid,
  output logic      frame_done
);

  bundle_t bund;
  logic    bund_valid;
  logic    bund_take;

  bebb_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .land      (land),
    .bund      (bund),
    .bund_valid(bund_valid),
    .bund_take (bund_take)
  );

  bebb_box u_box (
    .clk        (clk),
    .rst        (rst),
    .bund       (bund),
    .bund_valid (bund_valid),
    .bund_take  (bund_take),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .land_after (land_after),
    .box_min_row(box_min_row),
    .box_max_row(box_max_row),
    .box_min_col(box_min_col),
    .box_max_col(box_max_col),
    .box_valid  (box_valid),
    .frame_done (frame_done)
  );

  // A remaining land pixel always lies inside the box sent with it
  a_pixel_in_box: assert property (@(posedge clk) disable iff (rst)
    res_valid && land_after |->
      box_valid && (box_min_row <= out_row) && (out_row <= box_max_row) &&
      (box_min_col <= out_col) && (out_col <= box_max_col))
    else $error("remaining land pixel outside its box");

  // Without remaining land the box fields read zero
  a_empty_box_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !box_valid |->
      (box_min_row == '0) && (box_max_row == '0) &&
      (box_min_col == '0) && (box_max_col == '0))
    else $error("box fields not zero with no land");

  // The first result after a frame end starts a fresh box
  a_box_restarts: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && frame_done |=> !res_valid || (box_valid == land_after))
    else $error("box not cleared after frame end");

  // Input is held off only while a request is still draining
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> bund_valid && !bund_take)
    else $error("input stalled with nothing pending");

endmodule

`default_nettype wire

### hdl/bebb_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// Read-during-write to the same address returns the old data. No dependencies.
`default_nettype none

module bebb_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                         rdata_a,
  output logic      [WIDTH-1:0]                         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### hdl/bebb_window.sv
// Pixel window: size registers, row/column counters, line buffer and erosion decisions.
// Depends on bebb_pkg and bebb_ram; hands decided pixels to bebb_box as one request.
`default_nettype none

module bebb_window
  import bebb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cfg_we,
  input  wire logic    cfg_index,
  input  wire dim_t    cfg_data,
  input  wire logic    pix_valid,
  output logic         pix_stall,
  input  wire logic    land,
  output bundle_t      bund,
  output logic         bund_valid,
  input  wire logic    bund_take
);

  // Size registers
  dim_t img_width;
  dim_t img_height;
  dim_t w_eff;
  dim_t h_eff;

  // Position and current-row history
  col_t       col_count;
  row_t       row_count;
  logic [1:0] left_pixels;
  logic       up_left;     // previous row, one column to the left

  // Line buffer: bit 1 = row before previous, bit 0 = previous row
  logic [1:0] ram_a;
  logic [1:0] ram_b;
  logic [1:0] wr_q;
  logic       hit_a;
  logic       hit_b;
  logic [1:0] cur_a;
  logic [1:0] cur_b;
  logic [1:0] wr_data;
  col_t       rd_a;
  col_t       rd_b;

  logic    accept;
  logic    last_col;
  logic    last_row;
  logic    x_ge1;
  logic    x_ge2;
  logic    y_ge1;
  logic    y_ge2;
  bundle_t bund_next;

  // Effective sizes, saturated to 1..max
  always_comb begin
    if (img_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(img_width) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = img_width;
    end
    if (img_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(img_height) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_height;
    end
  end

  // Position flags
  assign last_col = (32'(col_count) + 1) >= 32'(w_eff);
  assign last_row = (32'(row_count) + 1) >= 32'(h_eff);
  assign x_ge1    = 32'(col_count) >= 1;
  assign x_ge2    = 32'(col_count) >= 2;
  assign y_ge1    = 32'(row_count) >= 1;
  assign y_ge2    = 32'(row_count) >= 2;

  // Handshake: hold off while the last request is still draining
  assign pix_stall = bund_valid && !bund_take;
  assign accept    = pix_valid && !pix_stall;

  // Line buffer data with write-first bypass
  assign cur_a   = hit_a ? wr_q : ram_a;
  assign cur_b   = hit_b ? wr_q : ram_b;
  assign wr_data = {cur_a[0], land};

  // Read the column of the next pixel and the one after it
  always_comb begin
    rd_a = col_count;
    if (accept) begin
      rd_a = last_col ? '0 : col_count + 1'b1;
    end
    rd_b = rd_a + 1'b1;
  end

  bebb_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk    (clk),
    .we     (accept),
    .waddr  (col_count),
    .wdata  (wr_data),
    .raddr_a(rd_a),
    .raddr_b(rd_b),
    .rdata_a(ram_a),
    .rdata_b(ram_b)
  );

  // Erosion decisions for this pixel
  always_comb begin
    bund_next = '0;

    // Pixel one row above, now that its lower neighbour is known
    bund_next.mask[SLOT_ABOVE]    = y_ge1;
    bund_next.px[SLOT_ABOVE].row  = COORD_W'(row_count - 1'b1);
    bund_next.px[SLOT_ABOVE].col  = COORD_W'(col_count);
    bund_next.px[SLOT_ABOVE].land = erode(cur_a[0], y_ge2 && cur_a[1], land,
                                          x_ge1 && up_left, !last_col && cur_b[0]);
    bund_next.px[SLOT_ABOVE].done = 1'b0;

    // Last row: left neighbour, decided one column late
    bund_next.mask[SLOT_LEFT]    = last_row && x_ge1;
    bund_next.px[SLOT_LEFT].row  = COORD_W'(row_count);
    bund_next.px[SLOT_LEFT].col  = COORD_W'(col_count - 1'b1);
    bund_next.px[SLOT_LEFT].land = erode(left_pixels[0], y_ge1 && up_left, 1'b0,
                                         x_ge2 && left_pixels[1], land);
    bund_next.px[SLOT_LEFT].done = 1'b0;

    // Last pixel of the frame
    bund_next.mask[SLOT_HERE]    = last_row && last_col;
    bund_next.px[SLOT_HERE].row  = COORD_W'(row_count);
    bund_next.px[SLOT_HERE].col  = COORD_W'(col_count);
    bund_next.px[SLOT_HERE].land = erode(land, y_ge1 && cur_a[0], 1'b0,
                                         x_ge1 && left_pixels[0], 1'b0);
    bund_next.px[SLOT_HERE].done = 1'b1;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= DIM_RESET;
      img_height <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  img_width  <= cfg_data;
        REG_IMAGE_HEIGHT: img_height <= cfg_data;
        default:          img_height <= img_height;
      endcase
    end
  end

  // Counters, row history and request register
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      left_pixels <= '0;
      bund_valid  <= 1'b0;
      hit_a       <= 1'b0;
      hit_b       <= 1'b0;
    end else begin
      hit_a <= accept && (col_count == rd_a);
      hit_b <= accept && (col_count == rd_b);
      if (accept) begin
        bund_valid <= |bund_next.mask;
        if (last_col) begin
          col_count   <= '0;
          left_pixels <= '0;
          row_count   <= last_row ? '0 : row_count + 1'b1;
        end else begin
          col_count   <= col_count + 1'b1;
          left_pixels <= {left_pixels[0], land};
        end
      end else if (bund_take) begin
        bund_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wr_q <= wr_data;
    if (accept) begin
      bund    <= bund_next;
      up_left <= cur_a[0];
    end
  end

endmodule

`default_nettype wire

### hdl/bebb_box.sv
// Result sequencer: sends decided pixels one per cycle if not stalled; tracks land box.
// Depends on bebb_pkg; takes requests from bebb_window and drives the result port.
`default_nettype none

module bebb_box
  import bebb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire bundle_t bund,
  input  wire logic    bund_valid,
  output logic         bund_take,
  output logic         res_valid,
  input  wire logic    res_stall,
  output coord_t       out_row,
  output coord_t       out_col,
  output logic         land_after,
  output coord_t       box_min_row,
  output coord_t       box_max_row,
  output coord_t       box_min_col,
  output coord_t       box_max_col,
  output logic         box_valid,
  output logic         frame_done
);

  logic [NUM_SLOTS-1:0] sent;
  logic [NUM_SLOTS-1:0] rem;
  logic [NUM_SLOTS-1:0] pick;
  logic [NUM_SLOTS-1:0] rest;
  logic [SLOT_W-1:0]    sel;
  logic                 load;
  dec_t                 rec;

  // Box state
  coord_t min_row_reg;
  coord_t max_row_reg;
  coord_t min_col_reg;
  coord_t max_col_reg;
  logic   any_land;
  coord_t min_row_next;
  coord_t max_row_next;
  coord_t min_col_next;
  coord_t max_col_next;
  logic   any_land_next;

  // Pick the lowest pending slot
  always_comb begin
    rem = bund_valid ? (bund.mask & ~sent) : '0;
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (rem[i]) begin
        sel = SLOT_W'(i);
      end
    end
    pick = rem & (NUM_SLOTS'(1) << sel);
    rest = rem & ~pick;
  end

  assign load      = (rem != '0) && (!res_valid || !res_stall);
  assign bund_take = bund_valid && ((rem == '0) || (load && (rest == '0)));
  assign rec       = bund.px[sel];

  // Box including the picked pixel
  always_comb begin
    min_row_next  = min_row_reg;
    max_row_next  = max_row_reg;
    min_col_next  = min_col_reg;
    max_col_next  = max_col_reg;
    any_land_next = any_land;
    if (rec.land) begin
      if (rec.row < min_row_reg) min_row_next = rec.row;
      if (rec.row > max_row_reg) max_row_next = rec.row;
      if (rec.col < min_col_reg) min_col_next = rec.col;
      if (rec.col > max_col_reg) max_col_next = rec.col;
      any_land_next = 1'b1;
    end
  end

  // Control and box state
  always_ff @(posedge clk) begin
    if (rst) begin
      sent        <= '0;
      res_valid   <= 1'b0;
      min_row_reg <= '1;
      max_row_reg <= '0;
      min_col_reg <= '1;
      max_col_reg <= '0;
      any_land    <= 1'b0;
    end else begin
      if (bund_take) begin
        sent <= '0;
      end else if (load) begin
        sent <= sent | pick;
      end

      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      // The box starts over after the last pixel of a frame
      if (load) begin
        if (rec.done) begin
          min_row_reg <= '1;
          max_row_reg <= '0;
          min_col_reg <= '1;
          max_col_reg <= '0;
          any_land    <= 1'b0;
        end else begin
          min_row_reg <= min_row_next;
          max_row_reg <= max_row_next;
          min_col_reg <= min_col_next;
          max_col_reg <= max_col_next;
          any_land    <= any_land_next;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_row     <= rec.row;
      out_col     <= rec.col;
      land_after  <= rec.land;
      box_min_row <= any_land_next ? min_row_next : '0;
      box_max_row <= any_land_next ? max_row_next : '0;
      box_min_col <= any_land_next ? min_col_next : '0;
      box_max_col <= any_land_next ? max_col_next : '0;
      box_valid   <= any_land_next;
      frame_done  <= rec.done;
    end
  end

endmodule

`default_nettype wire
